// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the matcher core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(label, expr, msg) \
   `ASSERT_CLK(label, !(expr), msg)

`endif

// ===== rtl/core/mpbm_pkg.sv =====
// types and constants of the multi-pattern byte matcher
package mpbm_pkg;

   // transaction operations
   typedef enum logic [1:0] {
      OP_PATTERN = 2'd0,
      OP_BUILD   = 2'd1,
      OP_TEXT    = 2'd2
   } op_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_MATCH = 2'd0,
      KIND_BUILT = 2'd1,
      KIND_DROP  = 2'd2
   } kind_type;

   localparam int ALPHA_BITS  = 8;
   localparam int ALPHA_SIZE  = 256;
   localparam int LEN_BITS    = 11;
   localparam int START_BITS  = 32;
   localparam int ID_BITS     = 4;
   localparam int MAX_RESULTS = 16;
   localparam int N_BITS      = 5;

   localparam logic [LEN_BITS-1:0] LEN_MAX   = 11'd2047;
   localparam logic [N_BITS-1:0]   N_LAST    = 5'd15;
   localparam logic [N_BITS-1:0]   N_LIMIT   = 5'd16;

   // text position control
   typedef struct packed {
      logic clear;
      logic advance;
   } pos_ctl_type;

endpackage

// ===== rtl/core/mpbm_pos_calc.sv =====
// text position counter and match start computation
module mpbm_pos_calc #(
   parameter int POSITION_BITS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  mpbm_pkg::pos_ctl_type                    ctl,
   input  logic [mpbm_pkg::LEN_BITS-1:0]            length,
   output logic [mpbm_pkg::START_BITS-1:0]          start
);

   logic [POSITION_BITS-1:0] pos_ff;
   logic [POSITION_BITS-1:0] pos_in;
   logic [POSITION_BITS-1:0] len_ext;
   logic [POSITION_BITS-1:0] diff;

   // saturating position counter
   always_comb begin
      pos_in = pos_ff;
      if (ctl.clear) begin
         pos_in = '0;
      end else if (ctl.advance && (pos_ff != '1)) begin
         pos_in = pos_ff + POSITION_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // start of a match ending here, clamped at zero
   assign len_ext = POSITION_BITS'(length);
   assign diff    = pos_ff - len_ext + POSITION_BITS'(1);
   assign start   = (len_ext > pos_ff) ? '0 : mpbm_pkg::START_BITS'(diff);

endmodule

// ===== rtl/core/multi_pattern_byte_matcher_core.sv =====
// top level of the multi-pattern byte matcher
// Aho-Corasick matcher over bytes, command style.
// A transaction is taken when start is high and busy is low. req_operation selects
// a pattern byte, a build of the fail links, or a text byte.
// Results leave on the rsp_ ports, at most one per cycle, with rsp_valid high for one cycle;
// rsp_last marks the final result of a transaction. The receiver cannot stall.
// A pattern byte passes through S_PLOOK, and through S_PLINK too when it ends a recorded
// pattern; while the rest of a dropped pattern is skipped, each byte is taken in S_IDLE.
// A text byte walks fail links in S_TG and S_TF, visits each node on the output chain
// in S_TN and reports each match in S_TP. At most 16 matches are reported per text
// byte.
// A build pops each queued node (S_BPOP, S_BU, S_BFU), tries every symbol of it in S_BV
// and walks fail links in S_BW, S_BWG and S_BWF, reading child links from the goto memory.
// Reset: a clearing pass writes the goto and node pattern memories with busy high;
// afterwards the trie holds the root and its 256 fixed children, one per byte value.
// Text bytes before a build produce nothing and do not advance the position.
`include "assert_macros.svh"

module multi_pattern_byte_matcher_core #(
   parameter int NODES         = 1024,
   parameter int PATTERNS      = 16,
   parameter int POSITION_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_operation,
   input  logic [mpbm_pkg::ALPHA_BITS-1:0]       req_data_byte,
   input  logic                                  req_end_of_pattern,
   input  logic                                  req_start_of_text,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_kind,
   output logic [mpbm_pkg::START_BITS-1:0]       rsp_match_start,
   output logic [mpbm_pkg::LEN_BITS-1:0]         rsp_match_length,
   output logic [mpbm_pkg::ID_BITS-1:0]          rsp_pattern_id,
   output logic                                  rsp_last
);

   localparam int NB     = $clog2(NODES);
   localparam int GAW    = NB + mpbm_pkg::ALPHA_BITS;
   localparam int GDEPTH = NODES * mpbm_pkg::ALPHA_SIZE;
   localparam int PIW    = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
   localparam int PCW    = $clog2(PATTERNS + 1);
   localparam int LB     = mpbm_pkg::LEN_BITS;
   localparam int AB     = mpbm_pkg::ALPHA_BITS;

   typedef enum logic [15:0] {
      S_CLEAR = 16'h0001,
      S_IDLE  = 16'h0002,
      S_PLOOK = 16'h0004,
      S_PLINK = 16'h0008,
      S_BPOP  = 16'h0010,
      S_BU    = 16'h0020,
      S_BFU   = 16'h0040,
      S_BV    = 16'h0080,
      S_BW    = 16'h0100,
      S_BWG   = 16'h0200,
      S_BWF   = 16'h0400,
      S_TG    = 16'h0800,
      S_TF    = 16'h1000,
      S_TN    = 16'h2000,
      S_TP    = 16'h4000,
      S_TEND  = 16'h8000
   } state_type;

   // patterns owned by one node: first and last in load order
   typedef struct packed {
      logic           has;
      logic [PIW-1:0] first;
      logic [PIW-1:0] tail;
   } nfp_type;

   // link to the next pattern of the same node
   typedef struct packed {
      logic           has;
      logic [PIW-1:0] id;
   } pnext_type;

   function automatic logic [NB-1:0] root_child(input logic [AB-1:0] sym);
      root_child = NB'(sym) + NB'(1);
   endfunction

   // memories
   logic [NB-1:0] goto_mem_ff  [0:GDEPTH-1];
   logic [NB-1:0] fail_mem_ff  [0:NODES-1];
   nfp_type       nfp_mem_ff   [0:NODES-1];
   logic [NB-1:0] queue_mem_ff [0:NODES-1];
   pnext_type     pnext_mem_ff [0:PATTERNS-1];
   logic [LB-1:0] plen_mem_ff  [0:PATTERNS-1];

   logic [NB-1:0]  goto_rd_ff;
   logic [NB-1:0]  fail_rd_ff;
   nfp_type        nfp_rd_ff;
   logic [NB-1:0]  queue_rd_ff;
   pnext_type      pnext_rd_ff;
   logic [LB-1:0]  plen_rd_ff;

   // memory ports
   logic [GAW-1:0] goto_ra, goto_wa;
   logic           goto_we;
   logic [NB-1:0]  goto_wd;
   logic [NB-1:0]  fail_ra, fail_wa, fail_wd;
   logic           fail_we;
   logic [NB-1:0]  nfp_ra, nfp_wa;
   logic           nfp_we;
   nfp_type        nfp_wd;
   logic [NB-1:0]  q_ra, q_wa, q_wd;
   logic           q_we;
   logic [PIW-1:0] pat_ra, pn_wa, pl_wa;
   logic           pn_we, pl_we;
   pnext_type      pn_wd;
   logic [LB-1:0]  pl_wd;

   // control and payload registers
   state_type      state_ff, state_in;
   logic [GAW-1:0] clr_ff, clr_in;
   logic [AB-1:0]  byte_ff, byte_in;
   logic           eop_ff, eop_in;
   logic [NB-1:0]  load_node_ff, load_node_in;
   logic [LB-1:0]  load_len_ff, load_len_in;
   logic           drop_ff, drop_in;
   logic [NB:0]    node_cnt_ff, node_cnt_in;
   logic [PCW-1:0] pat_cnt_ff, pat_cnt_in;
   logic           built_ff, built_in;
   logic [NB-1:0]  scan_ff, scan_in;
   logic [NB:0]    head_ff, head_in;
   logic [NB:0]    tail_ff, tail_in;
   logic [NB-1:0]  u_ff, u_in;
   logic [NB-1:0]  fu_ff, fu_in;
   logic [AB-1:0]  c_ff, c_in;
   logic [NB-1:0]  v_ff, v_in;
   logic [NB-1:0]  w_ff, w_in;
   logic [NB-1:0]  child_ff, child_in;
   logic [PIW-1:0] id_ff, id_in;
   logic [NB-1:0]  fm_ff, fm_in;
   logic [PIW-1:0] p_ff, p_in;
   logic [mpbm_pkg::N_BITS-1:0] n_ff, n_in;
   logic           pend_valid_ff, pend_valid_in;
   logic [mpbm_pkg::START_BITS-1:0] pend_start_ff, pend_start_in;
   logic [LB-1:0]  pend_len_ff, pend_len_in;
   logic [PIW-1:0] pend_id_ff, pend_id_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_kind_ff, rsp_kind_in;
   logic [mpbm_pkg::START_BITS-1:0] rsp_start_ff, rsp_start_in;
   logic [LB-1:0]  rsp_len_ff, rsp_len_in;
   logic [mpbm_pkg::ID_BITS-1:0] rsp_id_ff, rsp_id_in;
   logic           rsp_last_ff, rsp_last_in;

   // helpers of the sequencer
   logic           accept;
   logic           adv_c;
   logic           set_fail;
   logic [NB-1:0]  fail_val;
   logic [NB-1:0]  bv;
   logic           chain;
   logic [NB-1:0]  chain_node;
   logic           end_load;
   logic [NB-1:0]  child_now;
   logic [NB-1:0]  cv;
   logic [NB-1:0]  v_now;
   logic [NB-1:0]  w0;
   logic [NB-1:0]  nv;
   logic [LB-1:0]  new_len;
   mpbm_pkg::pos_ctl_type pos_ctl;
   logic [mpbm_pkg::START_BITS-1:0] pos_start;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // position counter and start computation
   mpbm_pos_calc #(
      .POSITION_BITS(POSITION_BITS)
   ) u_pos (
      .clock  (clock),
      .reset  (reset),
      .ctl    (pos_ctl),
      .length (plen_rd_ff),
      .start  (pos_start)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      byte_in       = byte_ff;
      eop_in        = eop_ff;
      load_node_in  = load_node_ff;
      load_len_in   = load_len_ff;
      drop_in       = drop_ff;
      node_cnt_in   = node_cnt_ff;
      pat_cnt_in    = pat_cnt_ff;
      built_in      = built_ff;
      scan_in       = scan_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      u_in          = u_ff;
      fu_in         = fu_ff;
      c_in          = c_ff;
      v_in          = v_ff;
      w_in          = w_ff;
      child_in      = child_ff;
      id_in         = id_ff;
      fm_in         = fm_ff;
      p_in          = p_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_start_in = pend_start_ff;
      pend_len_in   = pend_len_ff;
      pend_id_in    = pend_id_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = mpbm_pkg::KIND_MATCH;
      rsp_start_in  = '0;
      rsp_len_in    = '0;
      rsp_id_in     = '0;
      rsp_last_in   = 1'b0;

      goto_ra  = {load_node_ff, byte_ff};
      goto_we  = 1'b0;
      goto_wa  = {load_node_ff, byte_ff};
      goto_wd  = '0;
      fail_ra  = w_ff;
      fail_we  = 1'b0;
      fail_wa  = v_ff;
      fail_wd  = '0;
      nfp_ra   = child_ff;
      nfp_we   = 1'b0;
      nfp_wa   = child_ff;
      nfp_wd   = '0;
      q_ra     = head_ff[NB-1:0];
      q_we     = 1'b0;
      q_wa     = tail_ff[NB-1:0];
      q_wd     = v_ff;
      pat_ra   = p_ff;
      pn_we    = 1'b0;
      pn_wa    = id_ff;
      pn_wd    = '0;
      pl_we    = 1'b0;
      pl_wa    = id_ff;
      pl_wd    = load_len_ff;
      pos_ctl  = '0;

      adv_c      = 1'b0;
      set_fail   = 1'b0;
      fail_val   = '0;
      bv         = v_ff;
      chain      = 1'b0;
      chain_node = fm_ff;
      end_load   = 1'b0;
      child_now  = (load_node_ff == '0) ? root_child(byte_ff) : goto_rd_ff;
      cv         = (child_now == '0) ? node_cnt_ff[NB-1:0] : child_now;
      new_len    = (load_len_ff == mpbm_pkg::LEN_MAX) ? mpbm_pkg::LEN_MAX :
                   load_len_ff + LB'(1);
      v_now      = (u_ff == '0) ? root_child(c_ff) : goto_rd_ff;
      w0         = req_start_of_text ? '0 : scan_ff;
      nv         = (w_ff == '0) ? root_child(byte_ff) : goto_rd_ff;

      unique case (state_ff)
         // clearing pass over the goto and node pattern memories
         S_CLEAR: begin
            goto_we = 1'b1;
            goto_wa = clr_ff;
            goto_wd = '0;
            if (clr_ff[AB-1:0] == '0) begin
               nfp_we = 1'b1;
               nfp_wa = clr_ff[GAW-1:AB];
               nfp_wd = '0;
            end
            clr_in = clr_ff + GAW'(1);
            if (clr_ff == GAW'(GDEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         // take a new transaction
         S_IDLE: begin
            if (accept) begin
               byte_in = req_data_byte;
               eop_in  = req_end_of_pattern;
               unique case (req_operation)
                  mpbm_pkg::OP_PATTERN: begin
                     if (drop_ff) begin
                        if (req_end_of_pattern) begin
                           end_load = 1'b1;
                        end
                     end else begin
                        goto_ra  = {load_node_ff, req_data_byte};
                        state_in = S_PLOOK;
                     end
                  end
                  mpbm_pkg::OP_BUILD: begin
                     q_we     = 1'b1;
                     q_wa     = '0;
                     q_wd     = '0;
                     head_in  = '0;
                     tail_in  = (NB+1)'(1);
                     state_in = S_BPOP;
                  end
                  mpbm_pkg::OP_TEXT: begin
                     if (built_ff) begin
                        pos_ctl.clear = req_start_of_text;
                        w_in          = w0;
                        goto_ra       = {w0, req_data_byte};
                        state_in      = S_TG;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // pattern byte: follow or create the child
         S_PLOOK: begin
            state_in = S_IDLE;
            if ((child_now == '0) && (node_cnt_ff >= (NB+1)'(NODES))) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = mpbm_pkg::KIND_DROP;
               rsp_last_in  = 1'b1;
               if (eop_ff) begin
                  end_load = 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
            end else begin
               if (child_now == '0) begin
                  goto_we     = 1'b1;
                  goto_wa     = {load_node_ff, byte_ff};
                  goto_wd     = cv;
                  node_cnt_in = node_cnt_ff + (NB+1)'(1);
                  built_in    = 1'b0;
               end
               load_node_in = cv;
               load_len_in  = new_len;
               if (eop_ff) begin
                  if (pat_cnt_ff >= PCW'(PATTERNS)) begin
                     end_load     = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = mpbm_pkg::KIND_DROP;
                     rsp_last_in  = 1'b1;
                  end else begin
                     pl_we      = 1'b1;
                     pl_wa      = pat_cnt_ff[PIW-1:0];
                     pl_wd      = new_len;
                     pn_we      = 1'b1;
                     pn_wa      = pat_cnt_ff[PIW-1:0];
                     pn_wd      = '0;
                     pat_cnt_in = pat_cnt_ff + PCW'(1);
                     id_in      = pat_cnt_ff[PIW-1:0];
                     child_in   = cv;
                     nfp_ra     = cv;
                     state_in   = S_PLINK;
                  end
               end
            end
         end

         // append the pattern to the node's list
         S_PLINK: begin
            nfp_we = 1'b1;
            nfp_wa = child_ff;
            if (!nfp_rd_ff.has) begin
               nfp_wd = '{has: 1'b1, first: id_ff, tail: id_ff};
            end else begin
               pn_we  = 1'b1;
               pn_wa  = nfp_rd_ff.tail;
               pn_wd  = '{has: 1'b1, id: id_ff};
               nfp_wd = '{has: 1'b1, first: nfp_rd_ff.first, tail: id_ff};
            end
            end_load = 1'b1;
            state_in = S_IDLE;
         end

         // build: pop the next node
         S_BPOP: begin
            if (head_ff == tail_ff) begin
               built_in     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = mpbm_pkg::KIND_BUILT;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end else begin
               head_in  = head_ff + (NB+1)'(1);
               state_in = S_BU;
            end
         end

         S_BU: begin
            u_in     = queue_rd_ff;
            fail_ra  = queue_rd_ff;
            state_in = S_BFU;
         end

         S_BFU: begin
            fu_in    = fail_rd_ff;
            c_in     = '0;
            goto_ra  = {u_ff, AB'(0)};
            state_in = S_BV;
         end

         // child of u on symbol c
         S_BV: begin
            v_in = v_now;
            bv   = v_now;
            if (v_now == '0) begin
               adv_c = 1'b1;
            end else if (u_ff == '0) begin
               set_fail = 1'b1;
               fail_val = '0;
               adv_c    = 1'b1;
            end else begin
               w_in     = fu_ff;
               state_in = S_BW;
            end
         end

         // walk the fail chain of u for symbol c
         S_BW: begin
            if (w_ff == '0) begin
               set_fail = 1'b1;
               fail_val = root_child(c_ff);
               adv_c    = 1'b1;
            end else begin
               goto_ra  = {w_ff, c_ff};
               state_in = S_BWG;
            end
         end

         S_BWG: begin
            if (goto_rd_ff != '0) begin
               set_fail = 1'b1;
               fail_val = goto_rd_ff;
               adv_c    = 1'b1;
            end else begin
               fail_ra  = w_ff;
               state_in = S_BWF;
            end
         end

         S_BWF: begin
            w_in     = fail_rd_ff;
            state_in = S_BW;
         end

         // text: find the goto target from the current node
         S_TG: begin
            if ((w_ff == '0) || (goto_rd_ff != '0)) begin
               scan_in  = nv;
               n_in     = '0;
               nfp_ra   = nv;
               fail_ra  = nv;
               state_in = S_TN;
            end else begin
               fail_ra  = w_ff;
               state_in = S_TF;
            end
         end

         S_TF: begin
            w_in     = fail_rd_ff;
            goto_ra  = {fail_rd_ff, byte_ff};
            state_in = S_TG;
         end

         // text: patterns of the current output chain node
         S_TN: begin
            fm_in = fail_rd_ff;
            if (nfp_rd_ff.has) begin
               p_in     = nfp_rd_ff.first;
               pat_ra   = nfp_rd_ff.first;
               state_in = S_TP;
            end else begin
               chain      = 1'b1;
               chain_node = fail_rd_ff;
            end
         end

         // text: one match, the previous one leaves now
         S_TP: begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = mpbm_pkg::KIND_MATCH;
               rsp_start_in = pend_start_ff;
               rsp_len_in   = pend_len_ff;
               rsp_id_in    = mpbm_pkg::ID_BITS'(pend_id_ff);
            end
            pend_valid_in = 1'b1;
            pend_start_in = pos_start;
            pend_len_in   = plen_rd_ff;
            pend_id_in    = p_ff;
            n_in          = n_ff + mpbm_pkg::N_BITS'(1);
            if (n_ff == mpbm_pkg::N_LAST) begin
               state_in = S_TEND;
            end else if (pnext_rd_ff.has) begin
               p_in     = pnext_rd_ff.id;
               pat_ra   = pnext_rd_ff.id;
               state_in = S_TP;
            end else begin
               chain      = 1'b1;
               chain_node = fm_ff;
            end
         end

         // text: last match leaves, position moves on
         S_TEND: begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = mpbm_pkg::KIND_MATCH;
               rsp_start_in = pend_start_ff;
               rsp_len_in   = pend_len_ff;
               rsp_id_in    = mpbm_pkg::ID_BITS'(pend_id_ff);
               rsp_last_in  = 1'b1;
            end
            pend_valid_in   = 1'b0;
            pos_ctl.advance = 1'b1;
            state_in        = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // record a fail link and queue the node
      if (set_fail) begin
         fail_we = 1'b1;
         fail_wa = bv;
         fail_wd = fail_val;
         if (tail_ff < (NB+1)'(NODES)) begin
            q_we    = 1'b1;
            q_wa    = tail_ff[NB-1:0];
            q_wd    = bv;
            tail_in = tail_ff + (NB+1)'(1);
         end
      end

      // next symbol of the current build node
      if (adv_c) begin
         if (c_ff == '1) begin
            state_in = S_BPOP;
         end else begin
            c_in     = c_ff + AB'(1);
            goto_ra  = {u_ff, c_ff + AB'(1)};
            state_in = S_BV;
         end
      end

      // next node along the output chain
      if (chain) begin
         if (chain_node == '0) begin
            state_in = S_TEND;
         end else begin
            nfp_ra   = chain_node;
            fail_ra  = chain_node;
            state_in = S_TN;
         end
      end

      // pattern load finished or abandoned
      if (end_load) begin
         load_node_in = '0;
         load_len_in  = '0;
         drop_in      = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         load_node_ff  <= '0;
         load_len_ff   <= '0;
         drop_ff       <= 1'b0;
         node_cnt_ff   <= (NB+1)'(mpbm_pkg::ALPHA_SIZE + 1);
         pat_cnt_ff    <= '0;
         built_ff      <= 1'b0;
         scan_ff       <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         load_node_ff  <= load_node_in;
         load_len_ff   <= load_len_in;
         drop_ff       <= drop_in;
         node_cnt_ff   <= node_cnt_in;
         pat_cnt_ff    <= pat_cnt_in;
         built_ff      <= built_in;
         scan_ff       <= scan_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      eop_ff        <= eop_in;
      u_ff          <= u_in;
      fu_ff         <= fu_in;
      c_ff          <= c_in;
      v_ff          <= v_in;
      w_ff          <= w_in;
      child_ff      <= child_in;
      id_ff         <= id_in;
      fm_ff         <= fm_in;
      p_ff          <= p_in;
      pend_start_ff <= pend_start_in;
      pend_len_ff   <= pend_len_in;
      pend_id_ff    <= pend_id_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // goto memory
   always_ff @(posedge clock) begin
      if (goto_we) begin
         goto_mem_ff[goto_wa] <= goto_wd;
      end
      goto_rd_ff <= goto_mem_ff[goto_ra];
   end

   // fail link memory
   always_ff @(posedge clock) begin
      if (fail_we) begin
         fail_mem_ff[fail_wa] <= fail_wd;
      end
      fail_rd_ff <= fail_mem_ff[fail_ra];
   end

   // node pattern list memory
   always_ff @(posedge clock) begin
      if (nfp_we) begin
         nfp_mem_ff[nfp_wa] <= nfp_wd;
      end
      nfp_rd_ff <= nfp_mem_ff[nfp_ra];
   end

   // breadth-first queue memory
   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem_ff[q_wa] <= q_wd;
      end
      queue_rd_ff <= queue_mem_ff[q_ra];
   end

   // pattern link and length memories
   always_ff @(posedge clock) begin
      if (pn_we) begin
         pnext_mem_ff[pn_wa] <= pn_wd;
      end
      pnext_rd_ff <= pnext_mem_ff[pat_ra];
   end

   always_ff @(posedge clock) begin
      if (pl_we) begin
         plen_mem_ff[pl_wa] <= pl_wd;
      end
      plen_rd_ff <= plen_mem_ff[pat_ra];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_match_start  = rsp_start_ff;
   assign rsp_match_length = rsp_len_ff;
   assign rsp_pattern_id   = rsp_id_ff;
   assign rsp_last         = rsp_last_ff;

   // checks
   `ASSERT_CLK(a_rsp_needs_work, rsp_valid_ff |-> $past(busy), "result with no transaction in flight")
   `ASSERT_NEVER(a_node_cnt_range, node_cnt_ff > (NB+1)'(NODES), "node count beyond the node store")
   `ASSERT_NEVER(a_scan_known, (NB+1)'(scan_ff) >= node_cnt_ff, "scan node not yet allocated")
   `ASSERT_CLK(a_idle_no_pend, (state_ff == S_IDLE) |-> !pend_valid_ff, "match left pending when idle")
   `ASSERT_NEVER(a_result_cap, n_ff > mpbm_pkg::N_LIMIT, "too many matches for one text byte")

endmodule
